[rtl/psia_pkg.sv]
package psia_pkg;

   typedef enum logic [4:0] {
      OP_PACKSSDW = 5'd0,
      OP_PACKSSWB = 5'd1,
      OP_PACKUSWB = 5'd2,
      OP_PMINUB   = 5'd3,
      OP_PMAXUB   = 5'd4,
      OP_PMINSW   = 5'd5,
      OP_PMAXSW   = 5'd6,
      OP_PSUBUSB  = 5'd7,
      OP_PADDUSB  = 5'd8,
      OP_PADDSW   = 5'd9,
      OP_PCMPGTB  = 5'd10,
      OP_PCMPGTW  = 5'd11,
      OP_PSRAD    = 5'd12,
      OP_PSRAW    = 5'd13,
      OP_PMULHW   = 5'd14,
      OP_PSADBW   = 5'd15,
      OP_PMADDWD  = 5'd16,
      OP_PSLLDQ   = 5'd17,
      OP_PSRLDQ   = 5'd18
   } op_type;

   localparam int LANE_BYTES = 16;
   localparam int BYTE_SHIFT = 3;

   typedef struct packed {
      logic [4:0]  func;
      logic [63:0] first_low;
      logic [63:0] first_high;
      logic [63:0] second_low;
      logic [63:0] second_high;
      logic [7:0]  shift_count;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } rsp_type;

endpackage

[rtl/psia_datapath.sv]
// Three-stage datapath: stage 1 lane ops and products, stage 2 partial sums,
// stage 3 final select. Enable advances all stages together.
module psia_datapath
   import psia_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  req_type       in_word,
   output rsp_type       out_word
);

   // stage 1 registers
   logic [4:0]   op1_ff;
   logic [127:0] simple1_ff, simple1_in;
   logic [31:0]  prod1_ff [8];
   logic [31:0]  prod1_in [8];
   logic [7:0]   ad1_ff [16];
   logic [7:0]   ad1_in [16];
   // stage 2 registers
   logic [4:0]   op2_ff;
   logic [127:0] simple2_ff;
   logic [127:0] calc2_ff, calc2_in;
   // stage 3
   rsp_type      out_ff;

   logic [127:0] a, b;
   assign a = {in_word.first_high, in_word.first_low};
   assign b = {in_word.second_high, in_word.second_low};

   always_comb begin
      logic signed [31:0] sd;
      logic signed [15:0] sw, xw, yw;
      logic signed [16:0] s17;
      logic [7:0] xb, yb;
      logic [8:0] u9;
      logic [7:0] cnt;
      logic [4:0] c32;
      logic [3:0] c16;
      logic [10:0] bits;
      simple1_in = '0;
      cnt = in_word.shift_count;
      c32 = (cnt > 8'd31) ? 5'd31 : cnt[4:0];
      c16 = (cnt > 8'd15) ? 4'd15 : cnt[3:0];
      bits = {cnt, 3'b000};
      for (int i = 0; i < 8; i++) begin
         prod1_in[i] = 32'($signed(a[16*i +: 16]) * $signed(b[16*i +: 16]));
      end
      for (int i = 0; i < 16; i++) begin
         xb = a[8*i +: 8];
         yb = b[8*i +: 8];
         ad1_in[i] = (xb > yb) ? xb - yb : yb - xb;
      end
      case (in_word.func)
         OP_PACKSSDW: begin
            for (int i = 0; i < 4; i++) begin
               sd = a[32*i +: 32];
               simple1_in[16*i +: 16] = (sd > 32767) ? 16'h7fff :
                  (sd < -32768) ? 16'h8000 : sd[15:0];
               sd = b[32*i +: 32];
               simple1_in[16*(i+4) +: 16] = (sd > 32767) ? 16'h7fff :
                  (sd < -32768) ? 16'h8000 : sd[15:0];
            end
         end
         OP_PACKSSWB, OP_PACKUSWB: begin
            for (int i = 0; i < 16; i++) begin
               sw = (i < 8) ? a[16*i +: 16] : b[16*(i-8) +: 16];
               if (in_word.func == OP_PACKSSWB)
                  simple1_in[8*i +: 8] = (sw > 127) ? 8'h7f :
                     (sw < -128) ? 8'h80 : sw[7:0];
               else
                  simple1_in[8*i +: 8] = (sw > 255) ? 8'hff :
                     (sw < 0) ? 8'h00 : sw[7:0];
            end
         end
         OP_PMINUB, OP_PMAXUB, OP_PSUBUSB, OP_PADDUSB: begin
            for (int i = 0; i < 16; i++) begin
               xb = a[8*i +: 8];
               yb = b[8*i +: 8];
               u9 = {1'b0, xb} + {1'b0, yb};
               case (in_word.func)
                  OP_PMINUB:  simple1_in[8*i +: 8] = (xb < yb) ? xb : yb;
                  OP_PMAXUB:  simple1_in[8*i +: 8] = (xb < yb) ? yb : xb;
                  OP_PSUBUSB: simple1_in[8*i +: 8] = (xb > yb) ? xb - yb : 8'h00;
                  default:    simple1_in[8*i +: 8] = u9[8] ? 8'hff : u9[7:0];
               endcase
            end
         end
         OP_PMINSW, OP_PMAXSW, OP_PADDSW, OP_PCMPGTW: begin
            for (int i = 0; i < 8; i++) begin
               xw = a[16*i +: 16];
               yw = b[16*i +: 16];
               s17 = 17'(xw) + 17'(yw);
               case (in_word.func)
                  OP_PMINSW: simple1_in[16*i +: 16] = (xw < yw) ? xw : yw;
                  OP_PMAXSW: simple1_in[16*i +: 16] = (xw < yw) ? yw : xw;
                  OP_PADDSW: simple1_in[16*i +: 16] =
                     (s17[16] != s17[15]) ? (s17[16] ? 16'h8000 : 16'h7fff) : s17[15:0];
                  default:   simple1_in[16*i +: 16] = (xw > yw) ? 16'hffff : 16'h0;
               endcase
            end
         end
         OP_PCMPGTB: begin
            for (int i = 0; i < 16; i++)
               simple1_in[8*i +: 8] =
                  ($signed(a[8*i +: 8]) > $signed(b[8*i +: 8])) ? 8'hff : 8'h00;
         end
         OP_PSRAD: begin
            for (int i = 0; i < 4; i++)
               simple1_in[32*i +: 32] = $signed(a[32*i +: 32]) >>> c32;
         end
         OP_PSRAW: begin
            for (int i = 0; i < 8; i++)
               simple1_in[16*i +: 16] = $signed(a[16*i +: 16]) >>> c16;
         end
         OP_PSLLDQ: if (cnt < 8'(LANE_BYTES)) simple1_in = a << bits[6:0];
         OP_PSRLDQ: if (cnt < 8'(LANE_BYTES)) simple1_in = a >> bits[6:0];
         default: simple1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         op1_ff <= in_word.func;
         simple1_ff <= simple1_in;
         prod1_ff <= prod1_in;
         ad1_ff <= ad1_in;
      end
   end

   // stage 2: product high halves, dword sums, byte-difference sums
   always_comb begin
      logic [10:0] s0, s1;
      calc2_in = '0;
      s0 = '0;
      s1 = '0;
      case (op1_ff)
         OP_PMULHW: begin
            for (int i = 0; i < 8; i++) calc2_in[16*i +: 16] = prod1_ff[i][31:16];
         end
         OP_PMADDWD: begin
            for (int i = 0; i < 4; i++)
               calc2_in[32*i +: 32] = prod1_ff[2*i] + prod1_ff[2*i+1];
         end
         OP_PSADBW: begin
            for (int i = 0; i < 8; i++) begin
               s0 = s0 + 11'(ad1_ff[i]);
               s1 = s1 + 11'(ad1_ff[i+8]);
            end
            calc2_in = {53'd0, s1, 53'd0, s0};
         end
         default: calc2_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         op2_ff <= op1_ff;
         simple2_ff <= simple1_ff;
         calc2_ff <= calc2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (op2_ff == OP_PMULHW || op2_ff == OP_PMADDWD || op2_ff == OP_PSADBW)
            out_ff <= {calc2_ff[63:0], calc2_ff[127:64]};
         else
            out_ff <= {simple2_ff[63:0], simple2_ff[127:64]};
      end
   end

   assign out_word = out_ff;

endmodule

[rtl/packed_simd_integer_alu.sv]
// SSE2-style packed integer ALU on 128-bit operands. A new word is accepted
// each cycle unless the pipe is stalled; the three-stage datapath (lane ops
// and 16x16 products, partial sums, result select) advances as one pipe
// whenever its last stage is free or being drained, so rsp_ready low stalls
// the whole pipe without loss.
module packed_simd_integer_alu
   import psia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [2:0] vld_ff;
   logic enable;

   assign enable = !vld_ff[2] || rsp_ready;
   assign req_ready = enable;
   assign rsp_valid = vld_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[1:0], req_valid};
      end
   end

   psia_datapath u_dp (
      .clock    (clock),
      .enable   (enable),
      .in_word  (req_data),
      .out_word (rsp_data)
   );

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted word did not enter the pipe");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipe stalled with empty output");

endmodule
